// ----- hw/rtl/bitmap_page_frame_allocator_macros.svh -----
// Assertion helpers for the page allocator.
// Each expands to one labeled concurrent assertion clocked on clk,
// held off while rst_n is low.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define BPFA_ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger.
`define BPFA_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ----- hw/rtl/bpfa_pkg.sv -----
package bpfa_pkg;

  // Geometry
  localparam int MAX_PAGES = 4096;
  localparam int WORD_BITS = 64;
  localparam int MAX_RUN   = 64;
  localparam int NWORDS    = MAX_PAGES / WORD_BITS;
  localparam int WB_W      = $clog2(WORD_BITS);
  localparam int WA_W      = $clog2(NWORDS);

  // Field widths
  localparam int CMD_W   = 2;
  localparam int LEN_W   = 7;
  localparam int IDX_W   = 12;
  localparam int PC_W    = 13;
  localparam int BASE_W  = 40;
  localparam int FRAME_W = 41;
  localparam int ST_W    = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD     = 2'd2;

  // Configuration register indexes
  localparam logic CFG_BASE_FRAME = 1'b0;
  localparam logic CFG_PAGE_COUNT = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [LEN_W-1:0] run_length;
    logic [IDX_W-1:0] page_index;
  } bpfa_in_t;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [IDX_W-1:0]   first_index;
    logic [FRAME_W-1:0] frame;
    logic [PC_W-1:0]    used_count;
  } bpfa_out_t;

  // Controller to datapath
  typedef struct packed {
    logic            load;
    logic            rd_free;
    logic            scan_init;
    logic            scan_step;
    logic            hit_latch;
    logic            wr_hi;
    logic            wr_lo;
    logic            free_wr;
    logic            finish;
    logic            alloc_ok;
    logic [ST_W-1:0] status;
  } bpfa_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic is_alloc;
    logic is_free;
    logic bad;
    logic pc_zero;
    logic hit;
    logic last;
    logic lo_need;
  } bpfa_sts_t;

  // Window AND over len consecutive bits ending at each position.
  // Bits shifted in from below count as used.
  function automatic logic [2*WORD_BITS-1:0] run_window(
    input logic [2*WORD_BITS-1:0] v,
    input logic [LEN_W-1:0]       len
  );
    logic [2*WORD_BITS-1:0] p;
    logic [2*WORD_BITS-1:0] acc;
    p   = v;
    acc = '1;
    for (int j = 0; j < LEN_W; j++) begin
      if (len[j]) begin
        acc = p & (acc << (1 << j));
      end
      p = p & (p << (1 << j));
    end
    return acc;
  endfunction

  // Position of the lowest set bit
  function automatic logic [WB_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [WB_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = WB_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ----- hw/rtl/bpfa_ctrl.sv -----
module bpfa_ctrl import bpfa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  bpfa_sts_t sts,
  output bpfa_ctl_t ctl
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_FREE    = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_MARK_HI = 3'd4;
  localparam logic [2:0] S_MARK_LO = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    ctl.status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.bad) begin
          ctl.finish = 1'b1;
          ctl.status = ST_BAD;
          state_nxt  = S_IDLE;
        end else if (sts.is_free) begin
          ctl.rd_free = 1'b1;
          state_nxt   = S_FREE;
        end else if (sts.is_alloc) begin
          if (sts.pc_zero) begin
            ctl.finish = 1'b1;
            ctl.status = ST_NOSPACE;
            state_nxt  = S_IDLE;
          end else begin
            ctl.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
        end else begin
          // query
          ctl.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_FREE: begin
        ctl.free_wr = 1'b1;
        ctl.finish  = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_SCAN: begin
        if (sts.hit) begin
          ctl.hit_latch = 1'b1;
          state_nxt     = S_MARK_HI;
        end else if (sts.last) begin
          ctl.finish = 1'b1;
          ctl.status = ST_NOSPACE;
          state_nxt  = S_IDLE;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      S_MARK_HI: begin
        ctl.wr_hi = 1'b1;
        if (sts.lo_need) begin
          state_nxt = S_MARK_LO;
        end else begin
          ctl.finish   = 1'b1;
          ctl.alloc_ok = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_MARK_LO: begin
        ctl.wr_lo    = 1'b1;
        ctl.finish   = 1'b1;
        ctl.alloc_ok = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- hw/rtl/bpfa_dp.sv -----
module bpfa_dp import bpfa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  bpfa_in_t          in_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [BASE_W-1:0] cfg_wdata,
  input  bpfa_ctl_t         ctl,
  output bpfa_sts_t         sts,
  output logic              out_valid,
  output bpfa_out_t         out_data
);

  localparam int VW  = 2 * WORD_BITS;
  localparam int S_W = WB_W + 2;

  // Configuration and request
  logic [BASE_W-1:0] base_r;
  logic [PC_W-1:0]   pcount_r;
  bpfa_in_t          req_r;
  logic [PC_W-1:0]   used_r;
  logic [PC_W-1:0]   used_nxt;

  // Bitmap memory
  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [NWORDS-1:0]    valid_r;
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_vld_r;
  logic [WA_W-1:0]      rd_addr;
  logic [WA_W-1:0]      wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 mem_we;

  // Scan state
  logic [WA_W-1:0]      word_r;
  logic [WORD_BITS-1:0] prev_free_r;
  logic [WORD_BITS-1:0] prev_raw_r;
  logic [WORD_BITS-1:0] wr_hi_r;
  logic [WORD_BITS-1:0] wr_lo_r;
  logic                 lo_need_r;
  logic [IDX_W-1:0]     start_r;

  bpfa_out_t out_r;
  logic      out_valid_r;

  // Combinational terms
  logic [PC_W-1:0]      pc_eff;
  logic [PC_W-1:0]      pc_m1;
  logic [WA_W-1:0]      last_word;
  logic [PC_W-1:0]      rem;
  logic [WORD_BITS-1:0] lim_mask;
  logic [WORD_BITS-1:0] cur_raw;
  logic [WORD_BITS-1:0] cur_free;
  logic [VW-1:0]        win;
  logic [WORD_BITS-1:0] hits;
  logic [WB_W-1:0]      end_b;
  logic [S_W-1:0]       s_full;
  logic [S_W-2:0]       start_pos;
  logic [VW-1:0]        run_ones;
  logic [VW-1:0]        run_mask;
  logic [PC_W-1:0]      start_full;
  logic [WA_W-1:0]      idx_w;
  logic [WB_W-1:0]      idx_b;
  logic                 bit_set;

  assign idx_w = req_r.page_index[WB_W +: WA_W];
  assign idx_b = req_r.page_index[WB_W-1:0];

  // Effective page count and last word to scan
  assign pc_eff    = (pcount_r > PC_W'(MAX_PAGES)) ? PC_W'(MAX_PAGES) : pcount_r;
  assign pc_m1     = pc_eff - PC_W'(1);
  assign last_word = pc_m1[WB_W +: WA_W];

  // Request decode
  always_comb begin
    sts.is_alloc = 1'b0;
    sts.is_free  = 1'b0;
    sts.bad      = 1'b0;
    case (req_r.command)
      CMD_ALLOC: begin
        sts.is_alloc = 1'b1;
        sts.bad = (req_r.run_length == '0) || (req_r.run_length > LEN_W'(MAX_RUN));
      end
      CMD_FREE: begin
        sts.is_free = 1'b1;
        sts.bad     = (PC_W'(req_r.page_index) >= pc_eff);
      end
      CMD_QUERY: begin
        sts.bad = 1'b0;
      end
      default: begin
        sts.bad = 1'b1;
      end
    endcase
  end
  assign sts.pc_zero = (pc_eff == '0);

  // Current word, free bits below page count
  assign cur_raw = rd_vld_r ? rd_data_r : '0;
  assign rem     = pc_eff - PC_W'({word_r, {WB_W{1'b0}}});
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      lim_mask[b] = (PC_W'(b) < rem);
    end
  end
  assign cur_free = ~cur_raw & lim_mask;

  // Run search across previous and current word
  assign win  = run_window({cur_free, prev_free_r}, req_r.run_length);
  assign hits = win[VW-1:WORD_BITS];
  assign end_b = lowest_set(hits);
  assign sts.hit  = |hits;
  assign sts.last = (word_r == last_word);
  assign sts.lo_need = lo_need_r;

  // Run placement within the two-word window
  assign s_full     = S_W'(WORD_BITS) + S_W'(end_b) + S_W'(1) - S_W'(req_r.run_length);
  assign start_pos  = s_full[S_W-2:0];
  assign run_ones   = (VW'(1) << req_r.run_length) - VW'(1);
  assign run_mask   = run_ones << start_pos;
  assign start_full = PC_W'({word_r, {WB_W{1'b0}}}) + PC_W'(start_pos) - PC_W'(WORD_BITS);

  assign bit_set = cur_raw[idx_b];

  // Memory addressing
  always_comb begin
    if (ctl.rd_free) begin
      rd_addr = idx_w;
    end else if (ctl.scan_init) begin
      rd_addr = '0;
    end else begin
      rd_addr = word_r + WA_W'(1);
    end
  end

  always_comb begin
    mem_we  = ctl.wr_hi | ctl.wr_lo | ctl.free_wr;
    wr_addr = word_r;
    wr_data = wr_hi_r;
    if (ctl.free_wr) begin
      wr_addr = idx_w;
      wr_data = cur_raw & ~(WORD_BITS'(1) << idx_b);
    end else if (ctl.wr_lo) begin
      wr_addr = word_r - WA_W'(1);
      wr_data = wr_lo_r;
    end
  end

  // Bitmap array, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= valid_r[rd_addr];
  end

  // Per-word written flags; unwritten words read as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      pcount_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_FRAME: base_r   <= cfg_wdata;
        CFG_PAGE_COUNT: pcount_r <= cfg_wdata[PC_W-1:0];
        default:        base_r   <= base_r;
      endcase
    end
  end

  // Request and scan registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_r <= in_data;
    end
    if (ctl.scan_init) begin
      word_r      <= '0;
      prev_free_r <= '0;
      prev_raw_r  <= '0;
    end else if (ctl.scan_step) begin
      word_r      <= word_r + WA_W'(1);
      prev_free_r <= cur_free;
      prev_raw_r  <= cur_raw;
    end
    if (ctl.hit_latch) begin
      wr_hi_r   <= cur_raw | run_mask[VW-1:WORD_BITS];
      wr_lo_r   <= prev_raw_r | run_mask[WORD_BITS-1:0];
      lo_need_r <= |run_mask[WORD_BITS-1:0];
      start_r   <= start_full[IDX_W-1:0];
    end
  end

  // Used page count
  always_comb begin
    if (ctl.alloc_ok) begin
      used_nxt = used_r + PC_W'(req_r.run_length);
    end else if (ctl.free_wr && bit_set && (used_r != '0)) begin
      used_nxt = used_r - PC_W'(1);
    end else begin
      used_nxt = used_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (ctl.finish) begin
      used_r <= used_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_r.status     <= ctl.status;
      out_r.used_count <= used_nxt;
      if (ctl.alloc_ok) begin
        out_r.first_index <= start_r;
        out_r.frame       <= FRAME_W'(base_r) + FRAME_W'(start_r);
      end else begin
        out_r.first_index <= '0;
        out_r.frame       <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.finish;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- hw/rtl/bitmap_page_frame_allocator.sv -----
// Channel    | Ports                          | Transfer
// -----------+--------------------------------+-------------------------------------
// request    | start, busy, in_data           | edge with start high and busy low
// result     | out_valid, out_data            | edge ending the one out_valid cycle
// config     | cfg_we, cfg_index, cfg_wdata   | edge with cfg_we high
//
// Query and rejected requests finish in decode; a free reads its word, then writes it back;
// an allocate scans one 64-bit word per cycle until a run fits or the last word is scanned,
// then marks the run in the high word and, when the run crosses a word edge, in the low word.
// busy is low in the strobe cycle, so the next request may transfer there.
// rst_n is synchronous; the bitmap reads all free after reset with no sweep.
// The result side has no stall: each result is shown for exactly one cycle.
`include "bitmap_page_frame_allocator_macros.svh"

module bitmap_page_frame_allocator import bpfa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bpfa_in_t          in_data,
  output logic              out_valid,
  output bpfa_out_t         out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [BASE_W-1:0] cfg_wdata
);

  bpfa_ctl_t ctl;
  bpfa_sts_t sts;

  // Sequencer
  bpfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  // Bitmap, search and result
  bpfa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Checks
  `BPFA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request transfer did not raise busy")
  `BPFA_ASSERT_SAME(a_result_idle, out_valid, !busy, "result strobe while still busy")
  `BPFA_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe held two cycles")
  `BPFA_ASSERT_SAME(a_fail_zero, out_valid && out_data.status != ST_OK, out_data.first_index == '0 && out_data.frame == '0, "failed request returned nonzero page")

endmodule
